// ===== hdl/tpq_pkg.sv =====
// Shared codes, control struct and constants of the timestamp priority queue.
`timescale 1ns / 1ps

package tpq_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   // Qualified operation broadcast to every cell of the chain.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

// ===== hdl/tpq_channels.sv =====
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface tpq_req_if #(
   parameter int STAMP_BITS  = 16,
   parameter int SOURCE_BITS = 4
);
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic signed [tpq_pkg::VALUE_BITS-1:0] entry_value;
   logic [STAMP_BITS-1:0]           entry_stamp;
   logic [SOURCE_BITS-1:0]          entry_source;

   modport source (output valid, command, entry_value, entry_stamp, entry_source,
                   input ready);
   modport sink (input valid, command, entry_value, entry_stamp, entry_source,
                 output ready);
endinterface

interface tpq_rsp_if #(
   parameter int STAMP_BITS  = 16,
   parameter int SOURCE_BITS = 4,
   parameter int COUNT_BITS  = 5
);
   logic                            valid;
   logic                            ready;
   logic                            head_valid;
   logic signed [tpq_pkg::VALUE_BITS-1:0] head_value;
   logic [STAMP_BITS-1:0]           head_stamp;
   logic [SOURCE_BITS-1:0]          head_source;
   logic [COUNT_BITS-1:0]           occupancy;
   logic [tpq_pkg::STATUS_BITS-1:0] status;

   modport source (output valid, head_valid, head_value, head_stamp, head_source,
                   occupancy, status, input ready);
   modport sink (input valid, head_valid, head_value, head_stamp, head_source,
                 occupancy, status, output ready);
endinterface

// ===== hdl/tpq_cell.sv =====
// One slot of the sorted chain: compares the new key and shifts left or right.
`timescale 1ns / 1ps

module tpq_cell #(
   parameter int STAMP_BITS  = 16,
   parameter int SOURCE_BITS = 4
) (
   input  logic                            clock,
   input  tpq_pkg::cell_ctrl_type          ctrl,
   input  logic                            occupied,
   input  logic [tpq_pkg::VALUE_BITS-1:0]  new_value,
   input  logic [STAMP_BITS-1:0]           new_stamp,
   input  logic [SOURCE_BITS-1:0]          new_source,
   input  logic                            left_place,
   input  logic [tpq_pkg::VALUE_BITS-1:0]  left_value,
   input  logic [STAMP_BITS-1:0]           left_stamp,
   input  logic [SOURCE_BITS-1:0]          left_source,
   input  logic [tpq_pkg::VALUE_BITS-1:0]  right_value,
   input  logic [STAMP_BITS-1:0]           right_stamp,
   input  logic [SOURCE_BITS-1:0]          right_source,
   output logic                            place,
   output logic [tpq_pkg::VALUE_BITS-1:0]  value,
   output logic [STAMP_BITS-1:0]           stamp,
   output logic [SOURCE_BITS-1:0]          source
);

   logic [tpq_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [STAMP_BITS-1:0]          stamp_ff, stamp_in;
   logic [SOURCE_BITS-1:0]         source_ff, source_in;
   logic                           new_first;

   assign new_first = (new_stamp < stamp_ff) ||
                      ((new_stamp == stamp_ff) && (new_source < source_ff));

   // Monotone along the chain: the new entry lands in the first cell with place set.
   assign place = !occupied || new_first;

   always_comb begin
      value_in  = value_ff;
      stamp_in  = stamp_ff;
      source_in = source_ff;
      if (ctrl.push && place) begin
         if (left_place) begin
            value_in  = left_value;
            stamp_in  = left_stamp;
            source_in = left_source;
         end else begin
            value_in  = new_value;
            stamp_in  = new_stamp;
            source_in = new_source;
         end
      end else if (ctrl.pop) begin
         value_in  = right_value;
         stamp_in  = right_stamp;
         source_in = right_source;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      stamp_ff  <= stamp_in;
      source_ff <= source_in;
   end

   assign value  = value_ff;
   assign stamp  = stamp_ff;
   assign source = source_ff;

endmodule

// ===== hdl/timestamp_priority_queue.sv =====
// Sorted priority queue built as a shifting chain of slot cells.
//
// Usage: requests arrive on req_chan (valid/ready). command selects push or
// pop; a push carries entry_value, entry_stamp and entry_source. Entries are
// ordered by stamp, then source, an equal key goes behind the stored one.
// Each request yields one response on rsp_chan: the head after the operation,
// head_valid, occupancy and status (ok, push dropped on full, pop on empty).
// An empty queue reports a zero head.
// The response is registered and valid in the cycle after the transfer.
// One request per cycle while responses are taken; every cell compares its key
// with the new one in parallel and shifts in the same cycle, so the chain of
// QUEUE_DEPTH cells does not slow the rate.
// A stalled response holds req_chan.ready low until it is taken; a new
// request is accepted in the cycle the pending response transfers.
// Reset empties the queue (count to zero) and drops any pending response;
// req_chan.ready stays low while reset is held; slot contents are not cleared.
`timescale 1ns / 1ps

module timestamp_priority_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int STAMP_BITS  = 16,
   parameter int SOURCE_BITS = 4
) (
   input logic clock,
   input logic reset,
   tpq_req_if.sink   req_chan,
   tpq_rsp_if.source rsp_chan
);

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int VB = tpq_pkg::VALUE_BITS;

   logic [COUNT_BITS-1:0]          count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           head_valid_ff;
   logic [VB-1:0]                  head_value_ff;
   logic [STAMP_BITS-1:0]          head_stamp_ff;
   logic [SOURCE_BITS-1:0]         head_source_ff;
   logic [COUNT_BITS-1:0]          occupancy_ff;
   logic [tpq_pkg::STATUS_BITS-1:0] status_ff, status_in;

   logic                           accept;
   logic                           full;
   logic                           empty;
   tpq_pkg::cell_ctrl_type         ctrl;
   logic                           head_valid_in;
   logic [VB-1:0]                  head_value_in;
   logic [STAMP_BITS-1:0]          head_stamp_in;
   logic [SOURCE_BITS-1:0]         head_source_in;

   logic [QUEUE_DEPTH-1:0]         occupied;
   logic [QUEUE_DEPTH-1:0]         place;
   logic [VB-1:0]                  cell_value  [QUEUE_DEPTH];
   logic [STAMP_BITS-1:0]          cell_stamp  [QUEUE_DEPTH];
   logic [SOURCE_BITS-1:0]         cell_source [QUEUE_DEPTH];

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign full   = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   assign ctrl.push = accept && (req_chan.command == tpq_pkg::CMD_PUSH) && !full;
   assign ctrl.pop  = accept && (req_chan.command == tpq_pkg::CMD_POP) && !empty;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic              l_place;
         logic [VB-1:0]     l_value, r_value;
         logic [STAMP_BITS-1:0]  l_stamp, r_stamp;
         logic [SOURCE_BITS-1:0] l_source, r_source;

         assign occupied[i] = (COUNT_BITS'(i) < count_ff);

         if (i == 0) begin : g_first
            assign l_place  = 1'b0;
            assign l_value  = '0;
            assign l_stamp  = '0;
            assign l_source = '0;
         end else begin : g_inner_left
            assign l_place  = place[i-1];
            assign l_value  = cell_value[i-1];
            assign l_stamp  = cell_stamp[i-1];
            assign l_source = cell_source[i-1];
         end

         // The last cell refills from itself on a pop; that slot is then unused.
         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign r_value  = cell_value[i];
            assign r_stamp  = cell_stamp[i];
            assign r_source = cell_source[i];
         end else begin : g_inner_right
            assign r_value  = cell_value[i+1];
            assign r_stamp  = cell_stamp[i+1];
            assign r_source = cell_source[i+1];
         end

         tpq_cell #(
            .STAMP_BITS  (STAMP_BITS),
            .SOURCE_BITS (SOURCE_BITS)
         ) u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .occupied     (occupied[i]),
            .new_value    (req_chan.entry_value),
            .new_stamp    (req_chan.entry_stamp),
            .new_source   (req_chan.entry_source),
            .left_place   (l_place),
            .left_value   (l_value),
            .left_stamp   (l_stamp),
            .left_source  (l_source),
            .right_value  (r_value),
            .right_stamp  (r_stamp),
            .right_source (r_source),
            .place        (place[i]),
            .value        (cell_value[i]),
            .stamp        (cell_stamp[i]),
            .source       (cell_source[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = tpq_pkg::STATUS_OK;
      if (accept) begin
         case (req_chan.command)
            tpq_pkg::CMD_PUSH: begin
               if (full) status_in = tpq_pkg::STATUS_FULL;
               else count_in = count_ff + 1'b1;
            end
            tpq_pkg::CMD_POP: begin
               if (empty) status_in = tpq_pkg::STATUS_EMPTY;
               else count_in = count_ff - 1'b1;
            end
            default: status_in = tpq_pkg::STATUS_OK;
         endcase
      end
   end

   // Head after the operation, taken from what cell 0 will hold.
   always_comb begin
      head_value_in  = cell_value[0];
      head_stamp_in  = cell_stamp[0];
      head_source_in = cell_source[0];
      if (ctrl.push && place[0]) begin
         head_value_in  = req_chan.entry_value;
         head_stamp_in  = req_chan.entry_stamp;
         head_source_in = req_chan.entry_source;
      end else if (ctrl.pop) begin
         head_value_in  = cell_value[1];
         head_stamp_in  = cell_stamp[1];
         head_source_in = cell_source[1];
      end
      head_valid_in = (count_in != '0);
      if (!head_valid_in) begin
         head_value_in  = '0;
         head_stamp_in  = '0;
         head_source_in = '0;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         head_valid_ff  <= head_valid_in;
         head_value_ff  <= head_value_in;
         head_stamp_ff  <= head_stamp_in;
         head_source_ff <= head_source_in;
         occupancy_ff   <= count_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.head_valid  = head_valid_ff;
   assign rsp_chan.head_value  = head_value_ff;
   assign rsp_chan.head_stamp  = head_stamp_ff;
   assign rsp_chan.head_source = head_source_ff;
   assign rsp_chan.occupancy   = occupancy_ff;
   assign rsp_chan.status      = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in == tpq_pkg::STATUS_FULL) |=> $stable(count_ff))
      else $error("dropped push changed the count");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not decrement the count");

   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> head_valid_ff == (occupancy_ff != '0))
      else $error("head_valid disagrees with occupancy");

endmodule
